// ----- rtl/core/ths_pkg.sv -----
// Shared types and constants for the heap timer queue.
// No dependencies; used by every module in rtl/core.
package ths_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FIRE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic neg;      // a.deadline - b.deadline has its top bit set
    logic earlier;  // a leaves the heap before b
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_L,
    ST_DN_R,
    ST_FIN
  } state_t;

endpackage

// ----- rtl/core/timer_heap_scheduler_core.sv -----
// Channel  | Ports                                          | Handshake
// request  | in_operation, in_delay, in_timer_id            | start & !busy
// result   | out_kind, out_fired_id, out_at_time, out_last  | out_valid, one cycle
//
// Top level of the heap timer queue: sequencer around ths_cmp and ths_heap_ram.
// Depends on ths_pkg, ths_cmp, ths_heap_ram.
// Steps: the request is taken; an add then reads and compares the parent at each level
// climbed and writes the entry into place; each due check reads and compares the top
// entry, and a closing state ends the request; each fired timer first fetches the last
// entry, then reads both children and compares left and right at each level on the way
// down (a leaf only writes); the single compare unit and the single heap write port
// keep these steps in series. Synchronous active-low reset empties the queue and zeroes
// the time count; heap contents are not cleared. Results leave as one-cycle strobes,
// the final one in the first cycle with busy low; the receiver cannot stall them.
module timer_heap_scheduler_core
  import ths_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_delay,
  input  logic [7:0]  in_timer_id,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_fired_id,
  output logic [31:0] out_at_time,
  output logic        out_last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = IDX_W + 2;

  state_t           state_r, state_nxt;
  logic [31:0]      cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] par_r, par_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           e_r, e_nxt;
  entry_t           best_r, best_nxt;
  logic             take_left_r, take_left_nxt;
  logic             pend_v_r, pend_v_nxt;
  kind_t            pend_kind_r, pend_kind_nxt;
  logic [7:0]       pend_id_r, pend_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]       out_id_r, out_id_nxt;
  logic [31:0]      out_time_r, out_time_nxt;
  logic             out_last_r, out_last_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr0, raddr1;
  entry_t           wdata, rdata0, rdata1;
  entry_t           cmp_a, cmp_b;
  cmp_res_t         cmp_res;

  logic             gen, fin;
  kind_t            gen_kind;
  logic [7:0]       gen_id;
  logic [IDX_W:0]   left_w, right_w;
  logic             left_ok, right_ok;
  logic [CNT_W-1:0] cnt_dec;

  ths_heap_ram #(.DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  ths_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  assign left_w   = {pos_r, 1'b1};
  assign right_w  = left_w + 1'b1;
  assign left_ok  = XW'(left_w) < XW'(cnt_r);
  assign right_ok = XW'(right_w) < XW'(cnt_r);
  assign cnt_dec  = cnt_r - 1'b1;

  // operand select for the shared compare unit
  always_comb begin
    cmp_a = e_r;
    cmp_b = rdata0;
    case (state_r)
      ST_CHK_CMP: begin
        cmp_a = '{deadline: cur_r, id: 8'd0};
        cmp_b = rdata0;
      end
      ST_DN_L: begin
        cmp_a = rdata0;
        cmp_b = e_r;
      end
      ST_DN_R: begin
        cmp_a = rdata1;
        cmp_b = best_r;
      end
      default: begin
        cmp_a = e_r;
        cmp_b = rdata0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      cnt_r       <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    par_r       <= par_nxt;
    best_idx_r  <= best_idx_nxt;
    e_r         <= e_nxt;
    best_r      <= best_nxt;
    take_left_r <= take_left_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    par_nxt       = par_r;
    best_idx_nxt  = best_idx_r;
    e_nxt         = e_r;
    best_nxt      = best_r;
    take_left_nxt = take_left_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = e_r;
    re            = 1'b0;
    raddr0        = '0;
    raddr1        = '0;
    gen           = 1'b0;
    gen_kind      = KIND_FIRE;
    gen_id        = rdata0.id;
    fin           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt = '0;
          if (op_t'(in_operation) == OP_TICK) begin
            cur_nxt   = cur_r + 32'd1;
            state_nxt = ST_CHK_RD;
          end else if (cnt_r == CNT_W'(DEPTH)) begin
            gen       = 1'b1;
            gen_kind  = KIND_REJECT;
            gen_id    = in_timer_id;
            state_nxt = ST_CHK_RD;
          end else begin
            gen       = 1'b1;
            gen_kind  = KIND_ACCEPT;
            gen_id    = in_timer_id;
            e_nxt     = '{deadline: cur_r + 32'(in_delay), id: in_timer_id};
            pos_nxt   = IDX_W'(cnt_r);
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_INS_RD;
          end
        end
      end
      // sift up: hole at pos_r, new entry held in e_r
      ST_INS_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_CHK_RD;
        end else begin
          re        = 1'b1;
          raddr0    = (pos_r - 1'b1) >> 1;
          par_nxt   = (pos_r - 1'b1) >> 1;
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        we = 1'b1;
        if (cmp_res.earlier) begin
          wdata     = rdata0;
          pos_nxt   = par_r;
          state_nxt = ST_INS_RD;
        end else begin
          state_nxt = ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        if (n_r == N_W'(MAX_RESULTS) || cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          re        = 1'b1;
          raddr0    = '0;
          state_nxt = ST_CHK_CMP;
        end
      end
      ST_CHK_CMP: begin
        if (cmp_res.neg) begin
          state_nxt = ST_FIN;
        end else begin
          gen      = 1'b1;
          gen_kind = KIND_FIRE;
          gen_id   = rdata0.id;
          cnt_nxt  = cnt_dec;
          if (cnt_dec == '0) begin
            state_nxt = ST_CHK_RD;
          end else begin
            re        = 1'b1;
            raddr0    = IDX_W'(cnt_dec);
            state_nxt = ST_POP_LD;
          end
        end
      end
      ST_POP_LD: begin
        e_nxt     = rdata0;
        pos_nxt   = '0;
        state_nxt = ST_DN_RD;
      end
      // sift down: hole at pos_r, moving entry held in e_r
      ST_DN_RD: begin
        if (!left_ok) begin
          we        = 1'b1;
          state_nxt = ST_CHK_RD;
        end else begin
          re        = 1'b1;
          raddr0    = IDX_W'(left_w);
          raddr1    = IDX_W'(right_w);
          state_nxt = ST_DN_L;
        end
      end
      ST_DN_L: begin
        take_left_nxt = cmp_res.earlier;
        best_nxt      = cmp_res.earlier ? rdata0 : e_r;
        best_idx_nxt  = IDX_W'(left_w);
        state_nxt     = ST_DN_R;
      end
      ST_DN_R: begin
        we = 1'b1;
        if (right_ok && cmp_res.earlier) begin
          wdata     = rdata1;
          pos_nxt   = IDX_W'(right_w);
          state_nxt = ST_DN_RD;
        end else if (take_left_r) begin
          wdata     = best_r;
          pos_nxt   = best_idx_r;
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_CHK_RD;
        end
      end
      ST_FIN: begin
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // results produced so far by this request
    if (gen) begin
      n_nxt = n_nxt + 1'b1;
    end
  end

  // one result is held back so that out_last is known when it leaves
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = pend_kind_r;
    out_id_nxt    = pend_id_r;
    out_time_nxt  = cur_r;
    out_last_nxt  = fin;
    if (gen) begin
      out_valid_nxt = pend_v_r;
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = gen_kind;
      pend_id_nxt   = gen_id;
    end
    if (fin) begin
      out_valid_nxt = pend_v_r;
      pend_v_nxt    = 1'b0;
    end
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_fired_id = out_id_r;
  assign out_at_time  = out_time_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) <= XW'(DEPTH))
    else $error("entry count above heap depth");

  a_out_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result after the final one of a request");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");
`endif

endmodule

// ----- rtl/core/ths_cmp.sv -----
// Shared deadline compare unit: modular 32-bit difference, ties on id.
// Depends on ths_pkg.
module ths_cmp
  import ths_pkg::*;
(
  input  entry_t   a,
  input  entry_t   b,
  output cmp_res_t res
);

  logic [31:0] diff;

  assign diff        = a.deadline - b.deadline;
  assign res.neg     = diff[31];
  assign res.earlier = (diff == 32'd0) ? (a.id < b.id) : diff[31];

endmodule

// ----- rtl/core/ths_heap_ram.sv -----
// Heap storage: one write port, two registered read ports.
// Depends on ths_pkg.
module ths_heap_ram
  import ths_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output entry_t        rdata0,
  output entry_t        rdata1
);

  entry_t mem_r [DEPTH];
  entry_t rdata0_r;
  entry_t rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= mem_r[raddr0];
      rdata1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ----- verif/timer_heap_scheduler_core_tb.sv -----
// Self-checking testbench for timer_heap_scheduler_core: a directed table and a random
// add/tick mix; results are checked by an in-bench min-heap predictor or typed rows.
// Depends on ths_pkg and the RTL in rtl/core.
`timescale 1ns / 100ps

module timer_heap_scheduler_core_tb;
  import ths_pkg::*;

  localparam int HEAP_DEPTH   = DEPTH_DEF;
  localparam int PLAN_ROWS    = 25;
  localparam int RANDOM_ITEMS = 195;
  localparam int TOTAL_ITEMS  = PLAN_ROWS + RANDOM_ITEMS;
  localparam int QUIET_ITEMS  = 30;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [31:0] at_time;
    logic        last;
  } timer_event_t;

  // typed rows carry their result by hand: none, or one result naming the row's id
  typedef struct packed {
    op_t         op;
    logic [15:0] delay;
    logic [7:0]  id;
    logic        typed;
    logic        one_result;
    kind_t       kind;
    logic [31:0] at_time;
  } plan_row_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic        in_operation = 1'b0;
  logic [15:0] in_delay     = '0;
  logic [7:0]  in_timer_id  = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_fired_id;
  logic [31:0] out_at_time;
  logic        out_last;

  timer_heap_scheduler_core #(
    .DEPTH(HEAP_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_delay     (in_delay),
    .in_timer_id  (in_timer_id),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_fired_id (out_fired_id),
    .out_at_time  (out_at_time),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  logic [31:0]  model_time;
  logic [31:0]  model_deadline [HEAP_DEPTH];
  logic [7:0]   model_id [HEAP_DEPTH];
  int           model_count;
  timer_event_t step_events [$];
  timer_event_t awaited_events [$];

  int fail_count;
  int requests_sent;
  int adds_sent;
  int ticks_sent;
  int accepts_seen;
  int rejects_seen;
  int fires_seen;
  bit idle_mode;

  // slot a leaves the heap before slot b: modular deadline order, then lower id
  function automatic bit goes_first(int a, int b);
    logic [31:0] diff;
    diff = model_deadline[a] - model_deadline[b];
    if (diff == 32'd0) return model_id[a] < model_id[b];
    return diff[31];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [31:0] d;
    logic [7:0]  k;
    d = model_deadline[a];
    k = model_id[a];
    model_deadline[a] = model_deadline[b];
    model_id[a] = model_id[b];
    model_deadline[b] = d;
    model_id[b] = k;
  endfunction

  function automatic void heap_push(logic [31:0] deadline, logic [7:0] id);
    int pos;
    int parent;
    pos = model_count;
    model_deadline[pos] = deadline;
    model_id[pos] = id;
    model_count++;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!goes_first(pos, parent)) break;
      swap_slots(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void heap_pop_top();
    int pos;
    int left;
    int right;
    int best;
    pos = 0;
    model_count--;
    model_deadline[0] = model_deadline[model_count];
    model_id[0] = model_id[model_count];
    forever begin
      left = 2 * pos + 1;
      right = left + 1;
      best = pos;
      if (left < model_count && goes_first(left, best)) best = left;
      if (right < model_count && goes_first(right, best)) best = right;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic void note_event(kind_t kind, logic [7:0] id);
    timer_event_t ev;
    ev.kind = kind;
    ev.id = id;
    ev.at_time = model_time;
    ev.last = 1'b0;
    step_events.push_back(ev);
  endfunction

  function automatic void predict_timer_step(op_t op, logic [15:0] delay, logic [7:0] id);
    logic [31:0] late;
    step_events.delete();
    if (op == OP_ADD) begin
      if (model_count < HEAP_DEPTH) begin
        heap_push(model_time + 32'(delay), id);
        note_event(KIND_ACCEPT, id);
      end else begin
        note_event(KIND_REJECT, id);
      end
    end else begin
      model_time = model_time + 32'd1;
    end
    // drain everything due, capped per request; leftovers fire on the next one
    while (step_events.size() < MAX_RESULTS && model_count > 0) begin
      late = model_time - model_deadline[0];
      if (late[31]) break;
      note_event(KIND_FIRE, model_id[0]);
      heap_pop_top();
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic run_request(input op_t op, input logic [15:0] delay, input logic [7:0] id,
                             input bit hand_typed);
    int idle;
    idle = 0;
    if (requests_sent % 20 == 0) idle_mode = $urandom_range(0, 1);
    if (requests_sent < TOTAL_ITEMS - QUIET_ITEMS && idle_mode && $urandom_range(0, 2) == 0)
      idle = $urandom_range(1, 8);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_delay     <= delay;
    in_timer_id  <= id;
    do @(posedge clk); while (busy);
    requests_sent++;
    if (op == OP_ADD) adds_sent++;
    else ticks_sent++;
    predict_timer_step(op, delay, id);
    if (!hand_typed)
      foreach (step_events[k]) awaited_events.push_back(step_events[k]);
  endtask

  // ---------------------------------------------------------------- checking
  timer_event_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (out_kind == KIND_ACCEPT) accepts_seen++;
      else if (out_kind == KIND_REJECT) rejects_seen++;
      else if (out_kind == KIND_FIRE) fires_seen++;
      if (awaited_events.size() == 0) begin
        $error("unexpected result: kind %0d id %0h time %0d", out_kind, out_fired_id,
               out_at_time);
        fail_count++;
      end else begin
        want = awaited_events.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_fired_id !== want.id) begin
          $error("fired_id: expected %0h, actual %0h", want.id, out_fired_id);
          fail_count++;
        end
        if (out_at_time !== want.at_time) begin
          $error("at_time: expected %0d, actual %0d", want.at_time, out_at_time);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  plan_row_t directed_plan [PLAN_ROWS];

  initial begin
    timer_event_t typed_ev;
    int           burst_n;
    int           k;
    int           pick;
    int           guard;
    logic [15:0]  burst_delay;

    directed_plan = '{
      // tick with nothing due: no result
      '{OP_TICK, 16'h0000, 8'h00, 1'b1, 1'b0, KIND_ACCEPT, 32'd0},
      '{OP_ADD,  16'hFFFF, 8'hFF, 1'b1, 1'b1, KIND_ACCEPT, 32'd1},
      // zero delay: accepted, then fires in the same request
      '{OP_ADD,  16'h0000, 8'h00, 1'b0, 1'b0, KIND_ACCEPT, 32'd0},
      // equal deadlines with a duplicate id
      '{OP_ADD,  16'h0002, 8'h07, 1'b1, 1'b1, KIND_ACCEPT, 32'd1},
      '{OP_ADD,  16'h0002, 8'h03, 1'b1, 1'b1, KIND_ACCEPT, 32'd1},
      '{OP_ADD,  16'h0002, 8'h07, 1'b1, 1'b1, KIND_ACCEPT, 32'd1},
      '{OP_TICK, 16'h0000, 8'h00, 1'b1, 1'b0, KIND_ACCEPT, 32'd0},
      '{OP_TICK, 16'hFFFF, 8'hFF, 1'b0, 1'b0, KIND_ACCEPT, 32'd0},
      // fill the heap
      '{OP_ADD,  16'h0001, 8'h1C, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0001, 8'h12, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0001, 8'h1A, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0001, 8'h10, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0002, 8'h25, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0005, 8'h31, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0100, 8'h40, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h7FFF, 8'h55, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h8000, 8'h6A, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'hFFFE, 8'h7F, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0003, 8'h80, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0001, 8'h12, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0009, 8'hC3, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'h0004, 8'hE4, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      '{OP_ADD,  16'hAAAA, 8'h5B, 1'b1, 1'b1, KIND_ACCEPT, 32'd3},
      // heap full: rejected, heap untouched
      '{OP_ADD,  16'h0000, 8'hAB, 1'b1, 1'b1, KIND_REJECT, 32'd3},
      // five tied deadlines fire in id order
      '{OP_TICK, 16'h5555, 8'h55, 1'b0, 1'b0, KIND_ACCEPT, 32'd0}
    };

    model_time  = '0;
    model_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      run_request(directed_plan[r].op, directed_plan[r].delay, directed_plan[r].id,
                  directed_plan[r].typed);
      if (directed_plan[r].typed && directed_plan[r].one_result) begin
        typed_ev.kind    = directed_plan[r].kind;
        typed_ev.id      = directed_plan[r].id;
        typed_ev.at_time = directed_plan[r].at_time;
        typed_ev.last    = 1'b1;
        awaited_events.push_back(typed_ev);
      end
    end

    while (requests_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 2) begin
        // same-deadline burst, then ticks up to it: many timers fire at once
        burst_n = $urandom_range(2, 12);
        burst_delay = 16'($urandom_range(0, 3));
        for (k = 0; k < burst_n && requests_sent < TOTAL_ITEMS; k++)
          run_request(OP_ADD, burst_delay, 8'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k < burst_delay && requests_sent < TOTAL_ITEMS; k++)
          run_request(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          run_request(OP_TICK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      1'b0);
        else if (pick < 53)
          run_request(OP_ADD, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                      1'b0);
        else if (pick < 60)
          run_request(OP_ADD, 16'h0000, 8'($urandom_range(0, 255)), 1'b0);
        else
          run_request(OP_ADD, 16'($urandom_range(1, 12)), 8'($urandom_range(0, 255)), 1'b0);
      end
    end
    start <= 1'b0;

    guard = 0;
    while (awaited_events.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_events.size() != 0) begin
      $error("%0d expected results never arrived", awaited_events.size());
      fail_count++;
    end

    $display("requests: %0d adds, %0d ticks; %0d timers still queued at the end",
             adds_sent, ticks_sent, model_count);
    $display("results: %0d accepted, %0d rejected, %0d fired", accepts_seen, rejects_seen,
             fires_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ths_pkg.sv
rtl/core/ths_cmp.sv
rtl/core/ths_heap_ram.sv
rtl/core/timer_heap_scheduler_core.sv
verif/timer_heap_scheduler_core_tb.sv
